### rtl/core/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg
// Shared types and constants of the nearest-centroid assignment unit.
// ----------------------------------------------------------------------------
package nca_pkg;

	// squared distances are unsigned Q48.0 and saturate at 48 bits
	localparam int DIST_W = 48;
	// widest product the datapath can form (33 x 33 bits)
	localparam int PROD_MAX_W = 66;
	// configuration fields
	localparam int CFG_W = 5;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// register map, decoded on paddr[2]
	localparam logic REG_CLUSTER_COUNT = 1'b0;
	localparam logic REG_FEATURE_COUNT = 1'b1;

	// input modes
	localparam logic MODE_CENTROID = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} nca_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // transaction accepted, write store or buffer
		logic clear;  // new search, drop the best candidate
		logic issue;  // launch one multiply-accumulate
		logic first;  // first feature of a cluster
		logic last;   // last feature of a cluster
		logic zero;   // empty feature set, term counts as zero
	} nca_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
	} nca_stat_t;

endpackage

### rtl/core/nca_regs.sv
// ----------------------------------------------------------------------------
// nca_regs
// APB configuration registers: cluster count and feature count.
// ----------------------------------------------------------------------------
module nca_regs
	import nca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [CFG_W-1:0]  cluster_count,
	output logic [CFG_W-1:0]  feature_count
);

	logic             wr_en;
	logic [CFG_W-1:0] cluster_count_q;
	logic [CFG_W-1:0] feature_count_q;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= CFG_W'(1);
			feature_count_q <= CFG_W'(1);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CLUSTER_COUNT: cluster_count_q <= pwdata[CFG_W-1:0];
				REG_FEATURE_COUNT: feature_count_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			REG_CLUSTER_COUNT: prdata = APB_DW'(cluster_count_q);
			REG_FEATURE_COUNT: prdata = APB_DW'(feature_count_q);
			default:           prdata = '0;
		endcase
	end

	assign cluster_count = cluster_count_q;
	assign feature_count = feature_count_q;

endmodule

### rtl/core/nca_ctrl.sv
// ----------------------------------------------------------------------------
// nca_ctrl
// Controller: accepts transactions and walks the cluster/feature loop.
// ----------------------------------------------------------------------------
module nca_ctrl
	import nca_pkg::*;
#(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_FEATURES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  logic             last_feature,
	input  logic [CFG_W-1:0] cluster_count,
	input  logic [CFG_W-1:0] feature_count,
	input  nca_stat_t        stat,
	output logic             busy,
	output logic             done,
	output nca_cmd_t         cmd,
	output logic [(MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1)-1:0] k_idx,
	output logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] f_idx
);

	localparam int KW = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
	localparam int FW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
	localparam int NKW = $clog2(MAX_CLUSTERS + 1);
	localparam int NFW = $clog2(MAX_FEATURES + 1);

	nca_state_t     state_q;
	nca_state_t     state_d;
	logic [KW-1:0]  k_q;
	logic [FW-1:0]  f_q;
	logic [NKW-1:0] nk;
	logic [NFW-1:0] nf;
	logic           accept;
	logic           search;
	logic           k_last;
	logic           f_last;

	// effective counts, clipped to the store size
	assign nk = (32'(cluster_count) > MAX_CLUSTERS) ? NKW'(MAX_CLUSTERS) : NKW'(cluster_count);
	assign nf = (32'(feature_count) > MAX_FEATURES) ? NFW'(MAX_FEATURES) : NFW'(feature_count);

	assign accept = start & (state_q == ST_IDLE);
	assign search = accept & (mode == MODE_SAMPLE) & last_feature;
	assign k_last = (NKW'(k_q) + NKW'(1)) == nk;
	assign f_last = (nf == '0) || ((NFW'(f_q) + NFW'(1)) == nf);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (search) state_d = (nk == '0) ? ST_DONE : ST_ISSUE;
			end
			ST_ISSUE: begin
				if (k_last && f_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			f_q <= '0;
		end else if (search) begin
			k_q <= '0;
			f_q <= '0;
		end else if (state_q == ST_ISSUE) begin
			if (f_last) begin
				f_q <= '0;
				k_q <= k_q + KW'(1);
			end else begin
				f_q <= f_q + FW'(1);
			end
		end
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		cmd = '0;
		cmd.first = (f_q == '0);
		cmd.last = f_last;
		cmd.zero = (nf == '0);
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = accept;
				cmd.clear = search;
			end
			ST_ISSUE: cmd.issue = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  done = 1'b1;
			default:  ;
		endcase
	end

	assign k_idx = k_q;
	assign f_idx = f_q;

endmodule

### rtl/core/nca_datapath.sv
// ----------------------------------------------------------------------------
// nca_datapath
// Centroid store, sample buffer and a four-stage squared-distance pipeline
// feeding the running best-cluster compare.
// ----------------------------------------------------------------------------
module nca_datapath
	import nca_pkg::*;
#(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_FEATURES = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nca_cmd_t           cmd,
	input  logic [(MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1)-1:0] k_idx,
	input  logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] f_idx,
	input  logic               mode,
	input  logic [4:0]         cluster_index,
	input  logic [3:0]         feature_index,
	input  logic signed [15:0] sample_value,
	output nca_stat_t          stat,
	output logic [4:0]         cluster,
	output logic [DIST_W-1:0]  best_distance_sq
);

	localparam int KW = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
	localparam int FW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
	localparam int KW1 = KW + 1;
	localparam int DEPTH = MAX_CLUSTERS * MAX_FEATURES;
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int VB = VALUE_BITS;
	localparam int MW = VB + 1;
	localparam int PW = 2 * MW;
	localparam int SW = DIST_W + 1;

	logic [VB-1:0] cent_mem [DEPTH];
	logic [VB-1:0] samp_mem [MAX_FEATURES];

	logic [VB-1:0]         wr_val;
	logic                  cent_wr;
	logic                  samp_wr;
	logic [AW-1:0]         cent_wr_addr;
	logic [AW-1:0]         cent_rd_addr;
	logic [FW-1:0]         samp_wr_addr;

	// stage 1: operand read
	logic                  v_s1, first_s1, last_s1, zero_s1;
	logic [KW-1:0]         k_s1;
	logic [VB-1:0]         cent_s1, samp_s1;
	// stage 2: magnitude of difference
	logic                  v_s2, first_s2, last_s2;
	logic [KW-1:0]         k_s2;
	logic [MW-1:0]         mag_s2;
	logic signed [MW-1:0]  diff;
	// stage 3: square
	logic                  v_s3, first_s3, last_s3;
	logic [KW-1:0]         k_s3;
	logic [PW-1:0]         prod_s3;
	// stage 4: accumulate
	logic                  done_s4;
	logic                  v_s4;
	logic [KW-1:0]         k_s4;
	logic [DIST_W-1:0]     acc_s4;
	logic [PROD_MAX_W-1:0] prod_ext;
	logic [DIST_W-1:0]     term;
	logic [SW-1:0]         sum;
	// best candidate
	logic                  found_q;
	logic [KW-1:0]         best_k_q;
	logic [DIST_W-1:0]     best_q;

	// write decode
	assign wr_val = VB'({16'd0, sample_value});
	assign cent_wr = cmd.load && (mode == MODE_CENTROID) && (cluster_index != 5'd0)
		&& (32'(cluster_index) <= MAX_CLUSTERS) && (32'(feature_index) < MAX_FEATURES);
	assign samp_wr = cmd.load && (mode == MODE_SAMPLE) && (32'(feature_index) < MAX_FEATURES);
	assign cent_wr_addr = AW'((32'(cluster_index) - 32'd1) * MAX_FEATURES
		+ 32'(feature_index));
	assign samp_wr_addr = FW'(feature_index);
	assign cent_rd_addr = AW'(32'(k_idx) * MAX_FEATURES + 32'(f_idx));

	// centroid store
	always_ff @(posedge clk) begin
		if (cent_wr) cent_mem[cent_wr_addr] <= wr_val;
		cent_s1 <= cent_mem[cent_rd_addr];
	end

	// sample buffer
	always_ff @(posedge clk) begin
		if (samp_wr) samp_mem[samp_wr_addr] <= wr_val;
		samp_s1 <= samp_mem[f_idx];
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1 tags
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1 <= cmd.last;
		zero_s1 <= cmd.zero;
		k_s1 <= k_idx;
	end

	// stage 2: absolute difference
	assign diff = $signed({samp_s1[VB-1], samp_s1}) - $signed({cent_s1[VB-1], cent_s1});
	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		k_s2 <= k_s1;
		if (zero_s1)           mag_s2 <= '0;
		else if (diff[MW-1])   mag_s2 <= MW'(-diff);
		else                   mag_s2 <= MW'(diff);
	end

	// stage 3: square
	always_ff @(posedge clk) begin
		first_s3 <= first_s2;
		last_s3 <= last_s2;
		k_s3 <= k_s2;
		prod_s3 <= mag_s2 * mag_s2;
	end

	// stage 4: saturate term and accumulate
	assign prod_ext = PROD_MAX_W'(prod_s3);
	assign term = (|prod_ext[PROD_MAX_W-1:DIST_W]) ? '1 : prod_ext[DIST_W-1:0];
	assign sum = first_s3 ? SW'(term) : (SW'(acc_s4) + SW'(term));
	always_ff @(posedge clk) begin
		if (v_s3) begin
			acc_s4 <= sum[DIST_W] ? '1 : sum[DIST_W-1:0];
			k_s4 <= k_s3;
			done_s4 <= last_s3;
		end
	end

	// best cluster so far, lower number wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.clear) begin
			found_q <= 1'b0;
		end else if (v_s4 && done_s4 && (!found_q || (acc_s4 < best_q))) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && done_s4 && (!found_q || (acc_s4 < best_q))) begin
			best_q <= acc_s4;
			best_k_q <= k_s4;
		end
	end

	assign stat.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;
	assign cluster = found_q ? 5'(KW1'(best_k_q) + KW1'(1)) : 5'd0;
	assign best_distance_sq = found_q ? best_q : '1;

endmodule

### rtl/core/nearest_centroid_assign_unit.sv
// ----------------------------------------------------------------------------
// nearest_centroid_assign_unit
// Nearest-centroid assignment: stores centroids, buffers one sample and
// reports the cluster with the smallest saturated squared distance.
// ----------------------------------------------------------------------------
//
// channel  | handshake                     | payload
// ---------+-------------------------------+---------------------------------
// input    | start, busy (accept: start &  | mode, cluster_index,
//          | !busy)                        | feature_index, sample_value,
//          |                               | last_feature
// result   | done (one-cycle strobe)       | cluster, best_distance_sq
// config   | APB psel/penable/pwrite,      | paddr, pwdata, prdata
//          | pready tied high              |
//
// centroid writes and non-final sample features keep busy low
// a final sample feature keeps busy high until every term has passed through
// the single multiply-accumulate pipeline (one term per cycle, four stages)
// with nk = 0 the result comes in the cycle after the transaction
// done is high for the last busy cycle; the result cannot be stalled
// arst_n clears control state and sets both counts to 1; stores stay unset
//
module nearest_centroid_assign_unit
	import nca_pkg::*;
#(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_FEATURES = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [4:0]         cluster_index,
	input  logic [3:0]         feature_index,
	input  logic signed [15:0] sample_value,
	input  logic               last_feature,
	output logic               done,
	output logic [4:0]         cluster,
	output logic [DIST_W-1:0]  best_distance_sq
);

	localparam int KW = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
	localparam int FW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;

	logic [CFG_W-1:0] cluster_count;
	logic [CFG_W-1:0] feature_count;
	nca_cmd_t         cmd;
	nca_stat_t        stat;
	logic [KW-1:0]    k_idx;
	logic [FW-1:0]    f_idx;

	// configuration registers
	nca_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.cluster_count (cluster_count),
		.feature_count (feature_count)
	);

	// sequencing
	nca_ctrl #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_FEATURES (MAX_FEATURES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.mode          (mode),
		.last_feature  (last_feature),
		.cluster_count (cluster_count),
		.feature_count (feature_count),
		.stat          (stat),
		.busy          (busy),
		.done          (done),
		.cmd           (cmd),
		.k_idx         (k_idx),
		.f_idx         (f_idx)
	);

	// storage and distance arithmetic
	nca_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_FEATURES (MAX_FEATURES),
		.VALUE_BITS   (VALUE_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.k_idx            (k_idx),
		.f_idx            (f_idx),
		.mode             (mode),
		.cluster_index    (cluster_index),
		.feature_index    (feature_index),
		.sample_value     (sample_value),
		.stat             (stat),
		.cluster          (cluster),
		.best_distance_sq (best_distance_sq)
	);

endmodule

### rtl/core/nca_checker.sv
// ----------------------------------------------------------------------------
// nca_checker
// Port-level checks on transaction acceptance and result strobes.
// ----------------------------------------------------------------------------
module nca_checker
	import nca_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              mode,
	input logic              last_feature,
	input logic              done,
	input logic [4:0]        cluster,
	input logic [DIST_W-1:0] best_distance_sq
);

	// result strobe lasts one cycle and ends the busy period
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 (!done && !busy))
		else $error("done not a single cycle closing busy");

	// a store or non-final feature leaves busy and done low in the next cycle
	a_quick_item: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !(mode && last_feature)) |=> (!busy && !done))
		else $error("non-final transaction held the unit");

	// a final feature starts a search
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode && last_feature) |=> busy)
		else $error("final feature did not start a search");

	// no winner means the saturated cap is reported
	a_no_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cluster == 5'd0)) |-> (&best_distance_sq))
		else $error("cluster 0 reported with a finite distance");

endmodule

bind nearest_centroid_assign_unit nca_checker u_nca_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.mode             (mode),
	.last_feature     (last_feature),
	.done             (done),
	.cluster          (cluster),
	.best_distance_sq (best_distance_sq)
);
